// ----- src/tofwv_pkg.sv -----
`default_nettype none
package tofwv_pkg;

  localparam int TIME_W  = 32;
  localparam int PATH_W  = 20;
  localparam int SPEED_W = 21;
  localparam int MAG_W   = 21;
  localparam int DIR_W   = 15;

  localparam int SPEED_LIMIT = 1000000;
  localparam int HALF_SCALE  = 500000000;
  localparam int PATH_RESET  = 200000;

  // axis divider: quotient bits below the overflow check
  localparam int DIV_STEPS = 21;
  // 4 setup stages, one per quotient bit, one for saturate and sign
  localparam int AXIS_LAT  = 4 + DIV_STEPS + 1;

  localparam int SQRT_STEPS   = 21;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_SHIFT = 20;
  // magnitude and direction units share one latency
  localparam int VEC_LAT      = 23;

  localparam int DIR_RIGHT  = 9000;
  localparam int ATAN_CLAMP = 9000 * 256;

  typedef enum logic [0:0] {
    CFG_X_PATH = 1'b0,
    CFG_Y_PATH = 1'b1
  } cfg_reg_t;

  // atan(2^-i) in 1/256 hundredth of a degree
  function automatic logic [20:0] atan_step(input int i);
    logic [20:0] r;
    begin
      r = '0;
      unique case (i)
        0:  r = 21'd1152000;
        1:  r = 21'd680065;
        2:  r = 21'd359328;
        3:  r = 21'd182400;
        4:  r = 21'd91554;
        5:  r = 21'd45822;
        6:  r = 21'd22916;
        7:  r = 21'd11459;
        8:  r = 21'd5730;
        9:  r = 21'd2865;
        10: r = 21'd1432;
        11: r = 21'd716;
        12: r = 21'd358;
        13: r = 21'd179;
        14: r = 21'd90;
        15: r = 21'd45;
        16: r = 21'd22;
        17: r = 21'd11;
        18: r = 21'd6;
        19: r = 21'd3;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/tofwv_axis.sv -----
`default_nettype none
module tofwv_axis (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic [tofwv_pkg::PATH_W-1:0]         path,
  input  wire logic [tofwv_pkg::TIME_W-1:0]         tp,
  input  wire logic [tofwv_pkg::TIME_W-1:0]         tn,
  output logic signed [tofwv_pkg::SPEED_W-1:0]      speed
);
  import tofwv_pkg::*;

  localparam int A_W   = 49;
  localparam int DEN_W = 2 * TIME_W;
  localparam int NUM_W = 81;
  localparam int CMP_W = NUM_W + 4;
  localparam logic [A_W-1:0] HALF_C = A_W'(HALF_SCALE);

  logic                neg1, neg2, neg3;
  logic [TIME_W-1:0]   diff1;
  logic [DEN_W-1:0]    den1, den2, den3;
  logic [A_W-1:0]      a1;
  logic [63:0]         plo2;
  logic [A_W-1:0]      phi2;
  logic [NUM_W-1:0]    num3;

  logic [NUM_W-1:0]    d_rem  [0:DIV_STEPS];
  logic [DEN_W-1:0]    d_den  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] d_q   [0:DIV_STEPS];
  logic                d_neg  [0:DIV_STEPS];
  logic                d_over [0:DIV_STEPS];

  logic [DIV_STEPS-1:0] mag;
  logic                 sat;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= tn < tp;
      diff1 <= (tn < tp) ? tp - tn : tn - tp;
      den1  <= DEN_W'(tp) * DEN_W'(tn);
      a1    <= HALF_C * A_W'(path);
      neg2  <= neg1;
      den2  <= den1;
      plo2  <= 64'(a1[31:0]) * 64'(diff1);
      phi2  <= A_W'(a1[A_W-1:32]) * A_W'(diff1);
      neg3  <= neg2;
      den3  <= den2;
      num3  <= NUM_W'(plo2) + {phi2, 32'b0};
      // quotient needs more than DIV_STEPS bits: saturate
      d_over[0] <= {4'b0, num3[NUM_W-1:DIV_STEPS]} >= den3;
      d_rem[0]  <= num3;
      d_den[0]  <= den3;
      d_neg[0]  <= neg3;
      d_q[0]    <= '0;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    localparam int K = DIV_STEPS - 1 - i;
    logic [CMP_W-1:0] shifted;
    logic             ge;
    assign shifted = CMP_W'(d_den[i]) << K;
    assign ge      = CMP_W'(d_rem[i]) >= shifted;
    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[i+1]  <= ge ? NUM_W'(CMP_W'(d_rem[i]) - shifted) : d_rem[i];
        d_q[i+1]    <= {d_q[i][DIV_STEPS-2:0], ge};
        d_den[i+1]  <= d_den[i];
        d_neg[i+1]  <= d_neg[i];
        d_over[i+1] <= d_over[i];
      end
    end
  end

  assign sat = d_over[DIV_STEPS] || (d_q[DIV_STEPS] > DIV_STEPS'(SPEED_LIMIT));
  assign mag = sat ? DIV_STEPS'(SPEED_LIMIT) : d_q[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      speed <= d_neg[DIV_STEPS] ? -$signed(SPEED_W'(mag)) : $signed(SPEED_W'(mag));
    end
  end

endmodule
`default_nettype wire

// ----- src/tofwv_sqrt.sv -----
`default_nettype none
module tofwv_sqrt (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [tofwv_pkg::SPEED_W-1:0] xs,
  input  wire logic signed [tofwv_pkg::SPEED_W-1:0] ys,
  output logic [tofwv_pkg::MAG_W-1:0]              root
);
  import tofwv_pkg::*;

  localparam int PR_W  = 2 * SPEED_W;
  localparam int SQ_W  = 40;
  localparam int N_W   = SQ_W + 1;
  localparam int RES_W = N_W + 1;

  logic signed [PR_W-1:0] px, py;
  logic [SQ_W-1:0]  sqx, sqy;
  logic [N_W-1:0]   n_v   [0:SQRT_STEPS];
  logic [RES_W-1:0] res_v [0:SQRT_STEPS];

  assign px = PR_W'(xs) * PR_W'(xs);
  assign py = PR_W'(ys) * PR_W'(ys);

  always_ff @(posedge clk) begin
    if (en) begin
      sqx      <= px[SQ_W-1:0];
      sqy      <= py[SQ_W-1:0];
      n_v[0]   <= N_W'(sqx) + N_W'(sqy);
      res_v[0] <= '0;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam int B = 2 * (SQRT_STEPS - 1 - i);
    localparam logic [RES_W:0] BIT = (RES_W+1)'(1) << B;
    logic [RES_W:0] trial;
    logic           take;
    assign trial = (RES_W+1)'(res_v[i]) + BIT;
    assign take  = (RES_W+1)'(n_v[i]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        n_v[i+1]   <= take ? N_W'((RES_W+1)'(n_v[i]) - trial) : n_v[i];
        res_v[i+1] <= take ? RES_W'((res_v[i] >> 1) + RES_W'(BIT)) : (res_v[i] >> 1);
      end
    end
  end

  assign root = res_v[SQRT_STEPS][MAG_W-1:0];

endmodule
`default_nettype wire

// ----- src/tofwv_cordic.sv -----
`default_nettype none
module tofwv_cordic (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [tofwv_pkg::SPEED_W-1:0] xs,
  input  wire logic signed [tofwv_pkg::SPEED_W-1:0] ys,
  output logic signed [tofwv_pkg::DIR_W-1:0]        dir
);
  import tofwv_pkg::*;

  localparam int C_W = 48;
  localparam int Z_W = 24;
  localparam int ZC_W = 22;

  typedef struct packed {
    logic y_zero;
    logic x_zero;
    logic x_pos;
    logic flip;
  } dir_flags_t;

  logic signed [C_W-1:0] cx [0:CORDIC_STEPS];
  logic signed [C_W-1:0] cy [0:CORDIC_STEPS];
  logic signed [Z_W-1:0] z  [0:CORDIC_STEPS];
  dir_flags_t            fl [0:CORDIC_STEPS];

  logic [SPEED_W-1:0] ax, ay;
  logic [ZC_W-1:0]    zc;
  dir_flags_t         flc;
  logic [ZC_W-1:0]    dr;
  logic [DIR_W-1:0]   dmag;

  assign ax = (xs < 0) ? SPEED_W'(-xs) : SPEED_W'(xs);
  assign ay = (ys < 0) ? SPEED_W'(-ys) : SPEED_W'(ys);

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= $signed(C_W'(ay) << CORDIC_SHIFT);
      cy[0] <= $signed(C_W'(ax) << CORDIC_SHIFT);
      z[0]  <= '0;
      fl[0] <= '{y_zero: ys == 0, x_zero: xs == 0, x_pos: xs > 0,
                 flip: (xs < 0) != (ys < 0)};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [C_W-1:0] BIAS = C_W'((C_W'(1) << i) - 1);
    logic signed [C_W-1:0] dx, dy;
    logic signed [Z_W-1:0] ang;
    // shift toward zero
    assign dx  = $signed(cy[i] + ((cy[i] < 0) ? BIAS : '0)) >>> i;
    assign dy  = $signed(cx[i] + ((cx[i] < 0) ? BIAS : '0)) >>> i;
    assign ang = $signed(Z_W'(atan_step(i)));
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          z[i+1]  <= z[i] + ang;
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          z[i+1]  <= z[i] - ang;
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (z[CORDIC_STEPS] < 0) begin
        zc <= '0;
      end else if (z[CORDIC_STEPS] > Z_W'(ATAN_CLAMP)) begin
        zc <= ZC_W'(ATAN_CLAMP);
      end else begin
        zc <= ZC_W'(z[CORDIC_STEPS]);
      end
      flc <= fl[CORDIC_STEPS];
    end
  end

  assign dr   = (zc + ZC_W'(128)) >> 8;
  assign dmag = (dr > ZC_W'(DIR_RIGHT)) ? DIR_W'(DIR_RIGHT) : DIR_W'(dr);

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (flc.y_zero) begin
        dir <= flc.x_pos ? DIR_W'(DIR_RIGHT) :
               (flc.x_zero ? '0 : -$signed(DIR_W'(DIR_RIGHT)));
      end else if (flc.x_zero) begin
        dir <= '0;
      end else begin
        dir <= flc.flip ? -$signed(dmag) : $signed(dmag);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/tof_wind_vector_unit.sv -----
// Wind vector from four ultrasonic flight times.
// Input stream: one transaction carries the x positive, x negative, y positive
// and y negative flight times in picoseconds (32 bits each, x positive lowest).
// Output stream: x and y speed in mm/s (saturated at +-1000000), wind speed
// (integer square root) and direction in hundredths of a degree in m_tdata;
// m_tuser is set when any input time was zero, and m_tdata is then all zero.
// Path lengths (micrometres) are written through cfg_we/cfg_index/cfg_data;
// write them only while no transaction is in flight.
// From input to output transaction a result passes the axis dividers (one
// quotient bit per stage), then the square root and the CORDIC stages
// running side by side, then the output register.
// Throughput is one transaction per cycle unless the receiver stalls.
// Reset clears every valid bit and loads both path lengths with 200000.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
`default_nettype none
module tof_wind_vector_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // x_time_pos, x_time_neg, y_time_pos, y_time_neg
  input  wire logic [4*tofwv_pkg::TIME_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // x_speed, y_speed, wind_speed, wind_direction, 2 zero bits
  output logic [79:0]                           m_tdata,
  // time_error
  output logic                                  m_tuser,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [tofwv_pkg::PATH_W-1:0]     cfg_data
);
  import tofwv_pkg::*;

  localparam int LAT = AXIS_LAT + VEC_LAT + 1;
  localparam int OUT_W = 2 * SPEED_W + MAG_W + DIR_W;

  logic [PATH_W-1:0] x_path, y_path;
  logic              en;
  logic [LAT-1:0]    vld;
  logic [LAT-2:0]    err_d;
  logic [TIME_W-1:0] xp, xn, yp, yn;

  logic signed [SPEED_W-1:0] xs, ys;
  logic signed [SPEED_W-1:0] xs_d [0:VEC_LAT-1];
  logic signed [SPEED_W-1:0] ys_d [0:VEC_LAT-1];
  logic [MAG_W-1:0]          mag;
  logic signed [DIR_W-1:0]   dir;

  assign xp = s_tdata[TIME_W-1:0];
  assign xn = s_tdata[2*TIME_W-1:TIME_W];
  assign yp = s_tdata[3*TIME_W-1:2*TIME_W];
  assign yn = s_tdata[4*TIME_W-1:3*TIME_W];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_path <= PATH_W'(PATH_RESET);
      y_path <= PATH_W'(PATH_RESET);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_X_PATH: x_path <= cfg_data;
        CFG_Y_PATH: y_path <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_d <= {err_d[LAT-3:0], (xp == '0) || (xn == '0) || (yp == '0) || (yn == '0)};
      xs_d[0] <= xs;
      ys_d[0] <= ys;
      for (int i = 1; i < VEC_LAT; i++) begin
        xs_d[i] <= xs_d[i-1];
        ys_d[i] <= ys_d[i-1];
      end
      if (err_d[LAT-2]) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= {(80 - OUT_W)'(0), dir, mag, ys_d[VEC_LAT-1], xs_d[VEC_LAT-1]};
        m_tuser <= 1'b0;
      end
    end
  end

  tofwv_axis u_axis_x (.clk(clk), .en(en), .path(x_path), .tp(xp), .tn(xn), .speed(xs));
  tofwv_axis u_axis_y (.clk(clk), .en(en), .path(y_path), .tp(yp), .tn(yn), .speed(ys));

  tofwv_sqrt   u_sqrt   (.clk(clk), .en(en), .xs(xs), .ys(ys), .root(mag));
  tofwv_cordic u_cordic (.clk(clk), .en(en), .xs(xs), .ys(ys), .dir(dir));

endmodule
`default_nettype wire

// ----- src/tofwv_checker.sv -----
`default_nettype none
module tofwv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata,
  input wire logic        m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not track output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error result not zero");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[77:63]) >= -15'sd9000) &&
                 ($signed(m_tdata[77:63]) <= 15'sd9000))
    else $error("direction out of range");

endmodule

bind tof_wind_vector_unit tofwv_checker u_tofwv_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

// ----- bench/tb_tof_wind_vector_unit.sv -----
`timescale 1ns / 100ps
module tb_tof_wind_vector_unit;
  import tofwv_pkg::*;

  typedef struct packed {
    logic        err;
    logic [14:0] dir;
    logic [20:0] mag;
    logic [20:0] ys;
    logic [20:0] xs;
  } wind_t;

  class wind_scoreboard;
    wind_t pending[$];
    int errors;
    logic [19:0] x_path;
    logic [19:0] y_path;

    function longint axis_speed(logic [19:0] path, logic [31:0] tp, logic [31:0] tn);
      logic [127:0] num;
      logic [127:0] q;
      logic [63:0] den;
      logic neg;
      longint mag;
      if (tp == tn) return 0;
      neg = tn < tp;
      num = 128'(HALF_SCALE) * path * (neg ? tp - tn : tn - tp);
      den = 64'(tp) * 64'(tn);
      q = num / den;
      mag = (q > SPEED_LIMIT) ? SPEED_LIMIT : longint'(q);
      return neg ? -mag : mag;
    endfunction

    function longint int_sqrt(longint n);
      longint r;
      r = longint'($sqrt(real'(n)));
      while (r * r > n) r--;
      while ((r + 1) * (r + 1) <= n) r++;
      return r;
    endfunction

    function longint shr_zero(longint v, int s);
      return (v < 0) ? -((-v) >>> s) : (v >>> s);
    endfunction

    function longint atan_table(int i);
      longint t[20] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
                        5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};
      return t[i];
    endfunction

    function longint heading(longint xs, longint ys);
      longint cx, cy, z, d, dx, dy;
      if (ys == 0) return xs > 0 ? DIR_RIGHT : (xs < 0 ? -DIR_RIGHT : 0);
      if (xs == 0) return 0;
      cx = (ys < 0 ? -ys : ys) <<< CORDIC_SHIFT;
      cy = (xs < 0 ? -xs : xs) <<< CORDIC_SHIFT;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = shr_zero(cy, i);
        dy = shr_zero(cx, i);
        if (cy > 0) begin
          cx += dx; cy -= dy; z += atan_table(i);
        end else begin
          cx -= dx; cy += dy; z -= atan_table(i);
        end
      end
      if (z < 0) z = 0;
      if (z > ATAN_CLAMP) z = ATAN_CLAMP;
      d = (z + 128) / 256;
      if (d > DIR_RIGHT) d = DIR_RIGHT;
      return ((xs < 0) != (ys < 0)) ? -d : d;
    endfunction

    function void note_input(logic [127:0] d);
      wind_t w;
      longint xs, ys;
      w = '0;
      if (d[31:0] == 0 || d[63:32] == 0 || d[95:64] == 0 || d[127:96] == 0) begin
        w.err = 1'b1;
      end else begin
        xs = axis_speed(x_path, d[31:0], d[63:32]);
        ys = axis_speed(y_path, d[95:64], d[127:96]);
        w.xs = 21'(xs);
        w.ys = 21'(ys);
        w.mag = 21'(int_sqrt(xs * xs + ys * ys));
        w.dir = 15'(heading(xs, ys));
      end
      pending.push_back(w);
    endfunction

    function void check_result(logic [79:0] d, logic u);
      wind_t e, a;
      a = {u, d[77:0]};
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e !== a || d[79:78] !== 2'b00) begin
        $display("%0t expected xs=%0d ys=%0d mag=%0d dir=%0d err=%0b", $time,
                 $signed(e.xs), $signed(e.ys), e.mag, $signed(e.dir), e.err);
        $display("%0t actual   xs=%0d ys=%0d mag=%0d dir=%0d err=%0b pad=%b", $time,
                 $signed(a.xs), $signed(a.ys), a.mag, $signed(a.dir), a.err, d[79:78]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [19:0] cfg_data = '0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  wind_scoreboard wind_sb;

  always #6 clk = ~clk;

  tof_wind_vector_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) wind_sb.check_result(m_tdata, m_tuser);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #30ms;
    $display("tof_wind_vector_unit: mismatch");
    $finish;
  end

  task automatic send_times(logic [31:0] xp, logic [31:0] xn, logic [31:0] yp,
                            logic [31:0] yn);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {yn, yp, xn, xp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    wind_sb.note_input({yn, yp, xn, xp});
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (wind_sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_path(cfg_reg_t idx, logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_X_PATH) wind_sb.x_path = val;
    else wind_sb.x_path = wind_sb.x_path;
    if (idx == CFG_Y_PATH) wind_sb.y_path = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_time();
    logic [31:0] t;
    case ($urandom_range(9))
      0: t = $urandom;
      1: t = $urandom_range(3);
      2: t = 32'hFFFF_FFFF - $urandom_range(3);
      default: t = 32'd100_000_000 + $urandom_range(2_000_000);
    endcase
    return t;
  endfunction

  task automatic send_random;
    logic [31:0] xp, xn, yp, yn;
    xp = rand_time();
    xn = ($urandom_range(3) == 0) ? rand_time() : xp + $urandom_range(40000) - 20000;
    yp = rand_time();
    yn = ($urandom_range(3) == 0) ? rand_time() : yp + $urandom_range(40000) - 20000;
    if ($urandom_range(15) == 0) xn = xp;
    if ($urandom_range(15) == 0) yn = yp;
    send_times(xp, xn, yp, yn);
  endtask

  initial begin
    logic [19:0] paths[6] = '{20'd200000, 20'd0, 20'd1000000, 20'hFFFFF, 20'd1, 20'd150000};
    wind_sb = new();
    wind_sb.x_path = PATH_RESET;
    wind_sb.y_path = PATH_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset paths
    send_times(32'd100_000_000, 32'd100_010_000, 32'd100_000_000, 32'd99_990_000);
    send_times(0, 1, 1, 1);
    send_times(1, 0, 1, 1);
    send_times(1, 1, 0, 1);
    send_times(1, 1, 1, 0);
    send_times(0, 0, 0, 0);
    send_times(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_times(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_times(32'd100_000_000, 32'd100_000_000, 32'd100_000_000, 32'd100_010_000);
    send_times(32'd100_000_000, 32'd99_990_000, 32'd100_000_000, 32'd100_000_000);
    send_times(32'd100_000_000, 32'd100_000_000, 32'd100_000_000, 32'd100_000_000);
    send_times(32'd100_000_000, 32'd100_000_000, 32'd100_000_000, 32'd99_990_000);
    send_times(32'd100_000_000, 32'd100_005_000, 32'd100_000_000, 32'd100_005_000);
    send_times(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 15; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_path(CFG_X_PATH, paths[$urandom_range(5)]);
      write_path(CFG_Y_PATH, paths[$urandom_range(5)]);
      for (int n = 0; n < 170; n++) begin
        send_random();
        // hold until the pipeline is empty
        if (n == 85) begin
          s_tvalid <= 1'b0;
          while (wind_sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (wind_sb.errors == 0) $display("tof_wind_vector_unit: match");
    else $display("tof_wind_vector_unit: mismatch");
    $finish;
  end
endmodule
